/* hw/rtl/matmul_pkg.sv */
package matmul_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MaxDimDef    = 8;
  localparam int unsigned ElemWidthDef = 16;

  // fixed port widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned IdxPortW = 3;
  localparam int unsigned ElemPortW = 16;
  localparam int unsigned ProdW    = 35;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned CfgIdxW  = 2;

  // reset value of every dimension register
  localparam logic [CfgW-1:0] DIM_RESET = 4'd8;

  // input function codes
  localparam logic [FuncW-1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [FuncW-1:0] FUNC_START      = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NUM_COLS  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic                wr_left;
    logic                wr_right;
    logic                rd_en;
    logic                acc_clr;
    logic                out_load;
    logic                out_last;
    logic [IdxPortW-1:0] row;
    logic [IdxPortW-1:0] col;
    logic [IdxPortW-1:0] inner;
  } mm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mm_status_t;

endpackage

/* hw/rtl/matmul_datapath.sv */
module matmul_datapath import matmul_pkg::*; #(
  parameter int unsigned MAX_DIM    = MaxDimDef,
  parameter int unsigned ELEM_WIDTH = ElemWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mm_cmd_t                     cmd_i,
  output mm_status_t                  sts_o,
  input  logic [IdxPortW-1:0]         row_index_i,
  input  logic [IdxPortW-1:0]         col_index_i,
  input  logic signed [ElemPortW-1:0] element_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [IdxPortW-1:0]         out_row_o,
  output logic [IdxPortW-1:0]         out_col_o,
  output logic signed [ProdW-1:0]     product_value_o,
  output logic                        last_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(Depth);

  logic [ELEM_WIDTH-1:0] left_mem_q  [Depth];
  logic [ELEM_WIDTH-1:0] right_mem_q [Depth];

  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         left_addr;
  logic [AW-1:0]         right_addr;
  logic [ELEM_WIDTH-1:0] wr_data;

  logic signed [ELEM_WIDTH-1:0]   rd_a_q, rd_b_q;
  logic signed [2*ELEM_WIDTH-1:0] prod_q;
  logic                           v1_q, v2_q;
  logic [ProdW-1:0]               acc_q;

  logic                out_valid_q;
  logic [IdxPortW-1:0] out_row_q, out_col_q;
  logic [ProdW-1:0]    out_val_q;
  logic                out_last_q;

  // row-major addressing
  assign wr_addr    = AW'(row_index_i) * AW'(MAX_DIM) + AW'(col_index_i);
  assign left_addr  = AW'(cmd_i.row) * AW'(MAX_DIM) + AW'(cmd_i.inner);
  assign right_addr = AW'(cmd_i.inner) * AW'(MAX_DIM) + AW'(cmd_i.col);
  // low bits of the element field, zero-filled above the field
  assign wr_data    = ELEM_WIDTH'($unsigned(element_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_left) begin
      left_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.wr_right) begin
      right_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_a_q <= left_mem_q[left_addr];
      rd_b_q <= right_mem_q[right_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= rd_a_q * rd_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ProdW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q  <= cmd_i.row;
      out_col_q  <= cmd_i.col;
      out_val_q  <= acc_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.pipe_busy = v1_q | v2_q;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = $signed(out_val_q);
  assign last_o          = out_last_q;

endmodule

/* hw/rtl/matmul_ctrl.sv */
module matmul_ctrl import matmul_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic [IdxPortW-1:0] row_index_i,
  input  logic [IdxPortW-1:0] col_index_i,
  input  mm_status_t          sts_i,
  output mm_cmd_t             cmd_o
);

  localparam int unsigned IdxW = $clog2(MAX_DIM);

  ctrl_state_e state_q, state_d;

  logic [CfgW-1:0] num_rows_q, inner_dim_q, num_cols_q;
  logic [IdxW-1:0] nr_m1_q, nk_m1_q, nc_m1_q;
  logic [IdxW-1:0] nr_m1, nk_m1, nc_m1;
  logic [IdxW-1:0] i_q, j_q, k_q;
  logic            start_acc;
  logic            in_range;
  logic            last_entry;

  // out-of-range dimensions clamp to 1..MAX_DIM, kept as last index
  function automatic logic [IdxW-1:0] dim_last(input logic [CfgW-1:0] d);
    if (d == '0) begin
      return '0;
    end else if (int'(d) > MAX_DIM) begin
      return IdxW'(MAX_DIM - 1);
    end
    return IdxW'(d - 4'd1);
  endfunction

  assign nr_m1 = dim_last(num_rows_q);
  assign nk_m1 = dim_last(inner_dim_q);
  assign nc_m1 = dim_last(num_cols_q);

  assign in_range   = (int'(row_index_i) < MAX_DIM) && (int'(col_index_i) < MAX_DIM);
  assign start_acc  = (state_q == ST_IDLE) && in_valid_i && (func_i == FUNC_START);
  assign last_entry = (i_q == nr_m1_q) && (j_q == nc_m1_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_acc) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (k_q == nk_m1_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = last_entry ? ST_IDLE : ST_MAC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.row   = IdxPortW'(i_q);
    cmd_o.col   = IdxPortW'(j_q);
    cmd_o.inner = IdxPortW'(k_q);
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc_clr  = (func_i == FUNC_START);
          cmd_o.wr_left  = (func_i == FUNC_LOAD_LEFT) && in_range;
          cmd_o.wr_right = (func_i == FUNC_LOAD_RIGHT) && in_range;
        end
      end
      ST_MAC: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = last_entry;
          cmd_o.acc_clr  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      num_cols_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_ROWS:  num_rows_q  <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_NUM_COLS:  num_cols_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      nr_m1_q <= '0;
      nk_m1_q <= '0;
      nc_m1_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_acc) begin
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            nr_m1_q <= nr_m1;
            nk_m1_q <= nk_m1;
            nc_m1_q <= nc_m1;
          end
        end
        ST_MAC: begin
          k_q <= (k_q == nk_m1_q) ? '0 : k_q + 1'b1;
        end
        ST_EMIT: begin
          if (sts_i.out_free && !last_entry) begin
            if (j_q == nc_m1_q) begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register still held");

  a_no_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !(cmd_o.wr_left || cmd_o.wr_right))
    else $error("store written during a multiply");

  a_clear_on_empty_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_clr |-> !sts_i.pipe_busy)
    else $error("accumulator cleared with products in flight");

  a_inner_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (k_q <= nk_m1_q))
    else $error("inner index past inner dimension");

  a_drain_follows_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ($past(state_q) == ST_MAC) || ($past(state_q) == ST_DRAIN))
    else $error("drain entered from wrong state");

endmodule

/* hw/rtl/matrix_multiply.sv */
// load transactions are accepted while idle; the input stays ready after each one
// a start transaction walks the product in row-major order, one entry at a time:
// each entry runs its inner store reads (one store read per cycle), then multiply, add, emit
// throughput is bounded by the single multiply-accumulate unit and one read port per store
// rst_ni is asynchronous, active low: control idle, dimension registers back to 8
// store contents are not cleared by reset and are only defined once written
module matrix_multiply import matmul_pkg::*; #(
  parameter int unsigned MAX_DIM    = MaxDimDef,
  parameter int unsigned ELEM_WIDTH = ElemWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgW-1:0]             cfg_data_i,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [FuncW-1:0]            func_i,
  input  logic [IdxPortW-1:0]         row_index_i,
  input  logic [IdxPortW-1:0]         col_index_i,
  input  logic signed [ElemPortW-1:0] element_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [IdxPortW-1:0]         out_row_o,
  output logic [IdxPortW-1:0]         out_col_o,
  output logic signed [ProdW-1:0]     product_value_o,
  output logic                        last_o
);

  // controller owns the dimension registers, the handshake on the input side
  // and the row / column / inner counters; the datapath owns both element
  // stores, the read-multiply-accumulate pipe and the output register
  mm_cmd_t    cmd;
  mm_status_t sts;

  // controller: idle accepts loads and start; a start runs
  // mac (issue inner_dim reads) -> drain (wait for the pipe) -> emit, per entry
  matmul_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: registered store reads, registered product, 35-bit accumulator;
  // the output register lets the next entry compute while a result waits
  matmul_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_i       (element_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

endmodule
